/* src/ddwo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel odometry package
// Shared types, fixed-point constants, the arctangent table and the
// position update used by the odometry sequencer and its CORDIC unit.
// ----------------------------------------------------------------------------
package ddwo_pkg;

  localparam int ANG_W      = 34;
  localparam int STEP_CNT_W = 6;
  localparam int MUL_AW     = 36;
  localparam int MUL_BW     = 32;
  localparam int MUL_PW     = MUL_AW + MUL_BW;

  localparam logic signed [ANG_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [ANG_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [31:0] DIST_PER_TICK_RST = 32'd1317696;
  localparam logic [23:0] INV_BASE_RST      = 24'd218453;

  localparam logic REG_DIST_PER_TICK = 1'b0;
  localparam logic REG_INV_BASE      = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_P3A,
    ST_P3,
    ST_DTH,
    ST_MID,
    ST_MWRAP,
    ST_COR1,
    ST_PX_LO,
    ST_PX_HI,
    ST_PX_ADD,
    ST_PY_LO,
    ST_PY_HI,
    ST_PY_ADD,
    ST_HEAD,
    ST_HWRAP,
    ST_COR2,
    ST_OUT
  } state_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Adds a signed step of magnitude (hi << 2) + (lo >> 30) to a position
  // and saturates to 32 bits.
  function automatic logic signed [31:0] pos_step(input logic signed [31:0] acc,
                                                   input logic [MUL_PW-1:0] hi,
                                                   input logic [MUL_PW-1:0] lo,
                                                   input logic neg);
    logic [57:0] r;
    logic [33:0] rs;
    logic signed [35:0] t;
    logic signed [35:0] st;
    r  = {hi[55:0], 2'b00} + {26'd0, lo[61:30]};
    rs = (|r[57:33]) ? 34'h2_0000_0000 : r[33:0];
    st = $signed({2'b00, rs});
    t  = $signed({{4{acc[31]}}, acc}) + (neg ? -st : st);
    if (t > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

/* src/ddwo_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 36 by 32 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddwo_mul (
  input  wire logic                        clk,
  input  wire logic [ddwo_pkg::MUL_AW-1:0] a,
  input  wire logic [ddwo_pkg::MUL_BW-1:0] b,
  output logic      [ddwo_pkg::MUL_PW-1:0] p
);
  import ddwo_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule
`default_nettype wire

/* src/ddwo_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode sine and cosine, one micro-rotation per cycle, Q30 in and out.
// ----------------------------------------------------------------------------
module ddwo_cordic #(
  parameter int STEPS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [ddwo_pkg::ANG_W-1:0] angle,
  output logic                                   done,
  output logic signed [31:0]                     cos_q,
  output logic signed [31:0]                     sin_q
);
  import ddwo_pkg::*;

  logic signed [ANG_W-1:0] x, y, z;
  logic signed [ANG_W-1:0] dx, dy, at;
  logic [STEP_CNT_W-1:0]   cnt;
  logic                    run;

  always_comb begin
    dx = y >>> cnt[4:0];
    dy = x >>> cnt[4:0];
    at = $signed({4'd0, atan_q30(cnt[4:0])});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == STEP_CNT_W'(STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= GAIN_Q30;
      y   <= '0;
      z   <= angle;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (!z[ANG_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_comb begin
    if (x > ONE_Q30) begin
      cos_q = 32'(ONE_Q30);
    end else if (x < -ONE_Q30) begin
      cos_q = 32'(-ONE_Q30);
    end else begin
      cos_q = x[31:0];
    end
    if (y > ONE_Q30) begin
      sin_q = 32'(ONE_Q30);
    end else if (y < -ONE_Q30) begin
      sin_q = 32'(-ONE_Q30);
    end else begin
      sin_q = y[31:0];
    end
  end

endmodule
`default_nettype wire

/* src/diff_drive_wheel_odometry_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Differential drive wheel odometry
// Dead reckoning from four wheel encoder counts with a shared multiplier
// and a shared iterative CORDIC under one sequencer.
//
//   channel | direction | content
//   s_*     | in        | counts and speeds of four wheels
//   m_*     | out       | pose, quaternion and twist
//   cfg_*   | in        | register writes, always ready
//
// Between one accepted item and the next, an item passes the multiplier
// steps, two CORDIC passes and any heading wrap steps (at most three per
// item). The first item after reset only latches the counts. s_tready is
// high only while the sequencer is idle; the result register holds an item
// until m_tready takes it, and the next item is accepted meanwhile. rst is
// synchronous, active high.
// ----------------------------------------------------------------------------
module diff_drive_wheel_odometry_unit #(
  parameter int CORDIC_STEPS  = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // count_front_left, count_front_right, count_back_left, count_back_right,
  // speed_front_left, speed_front_right, speed_back_left, speed_back_right
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, heading, quat_z, quat_w, linear_speed, turn_rate, zero pad
  output logic      [199:0] m_tdata,
  // twist_valid
  output logic              m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import ddwo_pkg::*;

  localparam int DIST_W    = 31 + POS_FRAC_BITS;
  localparam int SHIFT_K   = 34 - POS_FRAC_BITS;
  localparam int DIST_HI_W = DIST_W - 32;

  state_t state, state_next;

  logic [31:0] dist_per_tick;
  logic [23:0] inv_base;

  logic [31:0] last_cnt [4];
  logic        awaiting_first;

  logic signed [33:0] sum_d, diff_d;
  logic signed [17:0] spd_sum, spd_diff;
  logic               spd_nz;
  logic [DIST_W-1:0]  dist_mag;
  logic               dist_neg;
  logic [35:0]        m1c;
  logic signed [32:0] dth;
  logic signed [ANG_W-1:0] hacc;
  logic               fold_neg;
  logic signed [31:0] c_val, s_val;
  logic [MUL_PW-1:0]  plo;
  logic signed [31:0] acc_x, acc_y;
  logic signed [30:0] acc_heading;
  logic signed [31:0] quat_z, quat_w;
  logic [15:0]        lin;
  logic [23:0]        turn;

  logic [31:0]        cnt_in [4];
  logic signed [15:0] spd_in [4];
  logic signed [31:0] delta [4];
  logic signed [33:0] sum_c, diff_c;
  logic signed [17:0] spd_sum_c, spd_diff_c;

  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  prod;
  logic               cor_start;
  logic signed [ANG_W-1:0] cor_angle;
  logic               cor_done;
  logic signed [31:0] cor_cos, cor_sin;

  logic               in_acc;
  logic               h_hi, h_lo;
  logic signed [ANG_W-1:0] fold_ang;
  logic               fold_flag;
  logic [31:0]        c_abs, s_abs;
  logic signed [32:0] dth_half;
  logic signed [25:0] turn_t;
  logic [25:0]        turn_q;
  logic [63:0]        dth_q;
  logic [30:0]        dth_m;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_in[i] = s_tdata[32*i +: 32];
      spd_in[i] = $signed(s_tdata[128 + 16*i +: 16]);
      delta[i]  = $signed(cnt_in[i] - last_cnt[i]);
    end
    sum_c  = 34'(delta[0]) + 34'(delta[1]) + 34'(delta[2]) + 34'(delta[3]);
    diff_c = (34'(delta[1]) + 34'(delta[3])) - (34'(delta[0]) + 34'(delta[2]));
    spd_sum_c  = 18'(spd_in[0]) + 18'(spd_in[1]) + 18'(spd_in[2]) + 18'(spd_in[3]);
    spd_diff_c = (18'(spd_in[1]) + 18'(spd_in[3])) - (18'(spd_in[0]) + 18'(spd_in[2]));
  end

  always_comb begin
    h_hi = hacc > PI_Q28;
    h_lo = hacc < -PI_Q28;
    if (hacc > HALF_PI_Q28) begin
      fold_ang  = hacc - PI_Q28;
      fold_flag = 1'b1;
    end else if (hacc < -HALF_PI_Q28) begin
      fold_ang  = hacc + PI_Q28;
      fold_flag = 1'b1;
    end else begin
      fold_ang  = hacc;
      fold_flag = 1'b0;
    end
    c_abs    = c_val[31] ? 32'(-c_val) : 32'(c_val);
    s_abs    = s_val[31] ? 32'(-s_val) : 32'(s_val);
    dth_half = (dth + $signed(33'(dth[32]))) >>> 1;
    dth_q    = prod[67:4];
    dth_m    = (|dth_q[63:31]) ? 31'h7FFF_FFFF : dth_q[30:0];
    turn_q   = {2'b00, prod[40:17]} + 26'(spd_diff[17] && (|prod[16:0]));
    turn_t   = spd_diff[17] ? -$signed(turn_q) : $signed(turn_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    cor_start  = 1'b0;
    cor_angle  = fold_ang <<< 2;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && !awaiting_first) begin
          state_next = ST_P1;
        end
      end
      ST_P1: begin
        mul_a      = {2'b00, (sum_d[33] ? -sum_d : sum_d)};
        mul_b      = dist_per_tick;
        state_next = ST_P2;
      end
      ST_P2: begin
        mul_a      = {2'b00, (diff_d[33] ? -diff_d : diff_d)};
        mul_b      = dist_per_tick;
        state_next = ST_P3A;
      end
      ST_P3A: state_next = ST_P3;
      ST_P3: begin
        mul_a      = m1c;
        mul_b      = {8'd0, inv_base};
        state_next = ST_DTH;
      end
      ST_DTH: begin
        mul_a      = {18'd0, (spd_diff[17] ? -spd_diff : spd_diff)};
        mul_b      = {8'd0, inv_base};
        state_next = ST_MID;
      end
      ST_MID: state_next = ST_MWRAP;
      ST_MWRAP: begin
        if (!h_hi && !h_lo) begin
          cor_start  = 1'b1;
          state_next = ST_COR1;
        end
      end
      ST_COR1: begin
        if (cor_done) begin
          state_next = ST_PX_LO;
        end
      end
      ST_PX_LO: begin
        mul_a      = 36'(dist_mag[31:0]);
        mul_b      = c_abs;
        state_next = ST_PX_HI;
      end
      ST_PX_HI: begin
        mul_a      = 36'(dist_mag[DIST_W-1 -: DIST_HI_W]);
        mul_b      = c_abs;
        state_next = ST_PX_ADD;
      end
      ST_PX_ADD: state_next = ST_PY_LO;
      ST_PY_LO: begin
        mul_a      = 36'(dist_mag[31:0]);
        mul_b      = s_abs;
        state_next = ST_PY_HI;
      end
      ST_PY_HI: begin
        mul_a      = 36'(dist_mag[DIST_W-1 -: DIST_HI_W]);
        mul_b      = s_abs;
        state_next = ST_PY_ADD;
      end
      ST_PY_ADD: state_next = ST_HEAD;
      ST_HEAD: state_next = ST_HWRAP;
      ST_HWRAP: begin
        cor_angle = hacc <<< 1;
        if (!h_hi && !h_lo) begin
          cor_start  = 1'b1;
          state_next = ST_COR2;
        end
      end
      ST_COR2: begin
        if (cor_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_tick <= DIST_PER_TICK_RST;
      inv_base      <= INV_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIST_PER_TICK: dist_per_tick <= cfg_data;
        REG_INV_BASE:      inv_base      <= cfg_data[23:0];
        default:           dist_per_tick <= dist_per_tick;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
      acc_x          <= '0;
      acc_y          <= '0;
      acc_heading    <= '0;
      for (int i = 0; i < 4; i++) begin
        last_cnt[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            awaiting_first <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              last_cnt[i] <= cnt_in[i];
            end
          end
        end
        ST_PX_ADD: acc_x <= pos_step(acc_x, prod, plo, dist_neg ^ c_val[31]);
        ST_PY_ADD: acc_y <= pos_step(acc_y, prod, plo, dist_neg ^ s_val[31]);
        ST_HWRAP: begin
          if (!h_hi && !h_lo) begin
            acc_heading <= hacc[30:0];
          end
        end
        default: acc_x <= acc_x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sum_d    <= sum_c;
        diff_d   <= diff_c;
        spd_sum  <= spd_sum_c;
        spd_diff <= spd_diff_c;
        spd_nz   <= (spd_in[0] != 0) || (spd_in[1] != 0) ||
                    (spd_in[2] != 0) || (spd_in[3] != 0);
      end
      ST_P2: begin
        dist_mag <= prod[SHIFT_K +: DIST_W];
        dist_neg <= sum_d[33];
      end
      ST_P3A: m1c <= (|prod[67:52]) ? 36'h8_0000_0000 : {1'b0, prod[51:17]};
      ST_DTH: dth <= diff_d[33] ? -$signed({2'b00, dth_m}) : $signed({2'b00, dth_m});
      ST_MID: begin
        hacc <= 34'(acc_heading) + 34'(dth_half);
        if (!spd_nz) begin
          lin  <= '0;
          turn <= '0;
        end else begin
          lin <= spd_sum[17:2];
          if (turn_t > 26'sd8388607) begin
            turn <= 24'h7F_FFFF;
          end else if (turn_t < -26'sd8388608) begin
            turn <= 24'h80_0000;
          end else begin
            turn <= turn_t[23:0];
          end
        end
      end
      ST_MWRAP: begin
        if (h_hi) begin
          hacc <= hacc - TWO_PI_Q28;
        end else if (h_lo) begin
          hacc <= hacc + TWO_PI_Q28;
        end else begin
          fold_neg <= fold_flag;
        end
      end
      ST_COR1: begin
        c_val <= fold_neg ? -cor_cos : cor_cos;
        s_val <= fold_neg ? -cor_sin : cor_sin;
      end
      ST_PX_HI, ST_PY_HI: plo <= prod;
      ST_HEAD: hacc <= 34'(acc_heading) + 34'(dth);
      ST_HWRAP: begin
        if (h_hi) begin
          hacc <= hacc - TWO_PI_Q28;
        end else if (h_lo) begin
          hacc <= hacc + TWO_PI_Q28;
        end
      end
      ST_COR2: begin
        quat_w <= cor_cos;
        quat_z <= cor_sin;
      end
      default: plo <= plo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, turn, lin, quat_w, quat_z, acc_heading, acc_y, acc_x};
      m_tuser <= spd_nz;
    end
  end

  ddwo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ddwo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

endmodule
`default_nettype wire
